// File: hw/rtl/clbw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbw_pkg
// Shared types, codes and init command tables of the character-LCD bus writer.
// ----------------------------------------------------------------------------
package clbw_pkg;

   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int COL_W      = 6;
   localparam int HOLD_W     = 9;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int INIT_IDX_W = 3;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // request operations
   localparam logic [OP_W-1:0] OP_DATA   = 2'd0;
   localparam logic [OP_W-1:0] OP_CMD    = 2'd1;
   localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;
   localparam logic [OP_W-1:0] OP_INIT   = 2'd3;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_BUS_MODE    = 2'd0;
   localparam logic [1:0] REG_ENABLE_HIGH = 2'd1;
   localparam logic [1:0] REG_ENABLE_LOW  = 2'd2;

   localparam logic BUS_MODE_8BIT = 1'b0;
   localparam logic BUS_MODE_4BIT = 1'b1;

   // LCD command bytes
   localparam logic [BYTE_W-1:0] CMD_FUNC_8BIT   = 8'h38;
   localparam logic [BYTE_W-1:0] CMD_FUNC_4BIT   = 8'h28;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON  = 8'h0E;
   localparam logic [BYTE_W-1:0] CMD_CLEAR       = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_RETURN_HOME = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [BYTE_W-1:0] ROW1_OFFSET     = 8'h40;

   localparam logic [HOLD_W-1:0] INIT_WAIT_MS = 9'd40;
   localparam logic [BYTE_W-1:0] SETTLE_MS    = 8'd1;
   localparam logic [BYTE_W-1:0] CLEAR_MS     = 8'd4;

   localparam logic [INIT_IDX_W-1:0] INIT_LAST_8BIT = 3'd3;
   localparam logic [INIT_IDX_W-1:0] INIT_LAST_4BIT = 3'd4;

   typedef struct packed {
      logic              bus_mode;
      logic [BYTE_W-1:0] enable_high_ms;
      logic [BYTE_W-1:0] enable_low_ms;
   } cfg_type;

   // one byte (or the power-up wait) queued for the bus sequencer
   typedef struct packed {
      logic              is_wait;
      logic              rs;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] extra_ms;
      logic              last;
   } job_type;

   function automatic logic [BYTE_W-1:0] init_cmd(input logic mode,
                                                  input logic [INIT_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] cmd;
      cmd = CMD_ENTRY_MODE;
      if (mode == BUS_MODE_8BIT) begin
         case (idx)
            3'd0:    cmd = CMD_FUNC_8BIT;
            3'd1:    cmd = CMD_DISPLAY_ON;
            3'd2:    cmd = CMD_CLEAR;
            default: cmd = CMD_ENTRY_MODE;
         endcase
      end else begin
         case (idx)
            3'd0:    cmd = CMD_RETURN_HOME;
            3'd1:    cmd = CMD_FUNC_4BIT;
            3'd2:    cmd = CMD_DISPLAY_ON;
            3'd3:    cmd = CMD_CLEAR;
            default: cmd = CMD_ENTRY_MODE;
         endcase
      end
      return cmd;
   endfunction

   // clear needs the long settle; everything else the short one
   function automatic logic [BYTE_W-1:0] init_settle(input logic mode,
                                                     input logic [INIT_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] ms;
      ms = (init_cmd(mode, idx) == CMD_CLEAR) ? CLEAR_MS : SETTLE_MS;
      return ms;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/clbw_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbw_if
// Valid/ready channels for host requests and bus phases.
// ----------------------------------------------------------------------------
interface clbw_req_if import clbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] value;
   logic              row;
   logic [COL_W-1:0]  column;
   logic [BYTE_W-1:0] settle_ms;

   modport source(output valid, operation, value, row, column, settle_ms, input ready);
   modport sink(input valid, operation, value, row, column, settle_ms, output ready);
endinterface

interface clbw_rsp_if import clbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              register_select;
   logic              read_write;
   logic              enable;
   logic [BYTE_W-1:0] data_lines;
   logic [HOLD_W-1:0] hold_ms;
   logic              last;

   modport source(output valid, register_select, read_write, enable, data_lines,
                  hold_ms, last, input ready);
   modport sink(input valid, register_select, read_write, enable, data_lines,
                hold_ms, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/clbw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbw_queue
// Small FIFO of byte jobs between request decode and the bus sequencer.
// ----------------------------------------------------------------------------
module clbw_queue import clbw_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule
`default_nettype wire

// File: hw/rtl/clbw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbw_front
// Accepts host requests and turns them into byte jobs; walks the init list.
// ----------------------------------------------------------------------------
module clbw_front import clbw_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   clbw_req_if.sink      req,
   output logic          push,
   output job_type       push_job,
   input  wire logic     q_full
);
   logic                  init_busy_ff, init_busy_in;
   logic [INIT_IDX_W-1:0] init_idx_ff, init_idx_in;
   logic [INIT_IDX_W-1:0] init_last;
   logic                  accept;
   logic [BYTE_W-1:0]     cursor_addr;

   assign req.ready = !init_busy_ff && !q_full;
   assign accept    = req.valid && req.ready;
   assign init_last = (cfg.bus_mode == BUS_MODE_4BIT) ? INIT_LAST_4BIT : INIT_LAST_8BIT;

   // row 1 starts at DDRAM 0x40; wraps mod 256
   assign cursor_addr = CMD_SET_DDRAM + (req.row ? ROW1_OFFSET : '0)
                        + {{(BYTE_W-COL_W){1'b0}}, req.column};

   always_comb begin
      push         = 1'b0;
      push_job     = '0;
      init_busy_in = init_busy_ff;
      init_idx_in  = init_idx_ff;
      if (init_busy_ff) begin
         if (!q_full) begin
            push              = 1'b1;
            push_job.data     = init_cmd(cfg.bus_mode, init_idx_ff);
            push_job.extra_ms = init_settle(cfg.bus_mode, init_idx_ff);
            push_job.last     = (init_idx_ff == init_last);
            init_idx_in       = init_idx_ff + 1'b1;
            if (init_idx_ff == init_last) begin
               init_busy_in = 1'b0;
            end
         end
      end else if (accept) begin
         push              = 1'b1;
         push_job.extra_ms = req.settle_ms;
         push_job.last     = 1'b1;
         case (req.operation)
            OP_DATA: begin
               push_job.rs   = 1'b1;
               push_job.data = req.value;
            end
            OP_CMD: begin
               push_job.data = req.value;
            end
            OP_CURSOR: begin
               push_job.data = cursor_addr;
            end
            OP_INIT: begin
               // power-up wait, then the command list
               push_job.is_wait  = 1'b1;
               push_job.extra_ms = '0;
               push_job.last     = 1'b0;
               init_busy_in      = 1'b1;
               init_idx_in       = '0;
            end
            default: begin
               push_job.data = req.value;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b0;
         init_idx_ff  <= '0;
      end else begin
         init_busy_ff <= init_busy_in;
         init_idx_ff  <= init_idx_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("job pushed into full queue");

endmodule
`default_nettype wire

// File: hw/rtl/clbw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbw_back
// Expands byte jobs into enable-high/low bus phases, one phase per beat.
// ----------------------------------------------------------------------------
module clbw_back import clbw_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire job_type  head,
   input  wire logic     q_empty,
   output logic          pop,
   clbw_rsp_if.source    rsp
);
   job_type           cur_job_ff, cur_job_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        last_phase;
   logic              done, adv, load;

   logic              out_valid_ff, out_valid_in;
   logic              out_rs_ff, out_rs_in;
   logic              out_en_ff, out_en_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [HOLD_W-1:0] out_hold_ff, out_hold_in;
   logic              out_last_ff, out_last_in;

   logic [BYTE_W-1:0] nib_hi, nib_lo;

   // wait: 1 phase; 8-bit: 2 phases; 4-bit: 4 phases
   assign last_phase = cur_job_ff.is_wait ? 2'd0 :
                       (cfg.bus_mode == BUS_MODE_4BIT) ? 2'd3 : 2'd1;
   assign done = (phase_ff == last_phase);
   assign adv  = cur_valid_ff && (!out_valid_ff || rsp.ready);
   assign load = !cur_valid_ff || (adv && done);
   assign pop  = load && !q_empty;

   assign nib_hi = {cur_job_ff.data[7:4], 4'h0};
   assign nib_lo = {cur_job_ff.data[3:0], 4'h0};

   always_comb begin
      out_rs_in   = cur_job_ff.rs;
      out_en_in   = !phase_ff[0];
      out_last_in = cur_job_ff.last && done;
      out_data_in = cur_job_ff.data;
      if (cfg.bus_mode == BUS_MODE_4BIT) begin
         out_data_in = phase_ff[1] ? nib_lo : nib_hi;
      end
      if (!phase_ff[0]) begin
         out_hold_in = {1'b0, cfg.enable_high_ms};
      end else if (done) begin
         out_hold_in = {1'b0, cfg.enable_low_ms} + {1'b0, cur_job_ff.extra_ms};
      end else begin
         out_hold_in = {1'b0, cfg.enable_low_ms};
      end
      if (cur_job_ff.is_wait) begin
         out_rs_in   = 1'b0;
         out_en_in   = 1'b0;
         out_data_in = '0;
         out_hold_in = INIT_WAIT_MS;
      end
   end

   always_comb begin
      cur_job_in   = cur_job_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      if (pop) begin
         cur_job_in   = head;
         cur_valid_in = 1'b1;
         phase_in     = '0;
      end else if (adv && done) begin
         cur_valid_in = 1'b0;
      end else if (adv) begin
         phase_in = phase_ff + 1'b1;
      end
      out_valid_in = adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff <= cur_job_in;
      if (adv) begin
         out_rs_ff   <= out_rs_in;
         out_en_ff   <= out_en_in;
         out_data_ff <= out_data_in;
         out_hold_ff <= out_hold_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.register_select = out_rs_ff;
   assign rsp.read_write      = 1'b0;
   assign rsp.enable          = out_en_ff;
   assign rsp.data_lines      = out_data_ff;
   assign rsp.hold_ms         = out_hold_ff;
   assign rsp.last            = out_last_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> phase_ff <= last_phase)
      else $error("phase counter past end of job");

endmodule
`default_nettype wire

// File: hw/rtl/char_lcd_bus_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_bus_writer
// Host requests to timed HD44780-style write phases on a character-LCD bus.
// ----------------------------------------------------------------------------
// Each request beat on req_bus becomes a run of phase beats on rsp_bus; the
// last phase of a request carries last = 1. Data/command/set-cursor requests
// give 2 phases in 8-bit mode and 4 in 4-bit mode; initialize gives a 40 ms
// wait phase plus the fixed command list: 9 phases (8-bit) or 21 (4-bit).
// Rate: one phase per clock while jobs are queued and rsp_bus.ready is high,
// set by the output register of the phase sequencer. The decode side takes a
// new request every clock while the job queue (QUEUE_DEPTH entries) has room,
// except during an initialize, which holds req_bus.ready low until its
// command list is queued (later when the queue fills behind a stalled rsp_bus).
// The first phase of a request passes through the job queue, the current-job
// register and the phase output register before rsp_bus.valid rises.
// Registers (APB, byte address 4*i): 0 bus_mode, 1 enable_high_ms,
// 2 enable_low_ms; write them only while the block is idle, since bus_mode
// is read as phases are produced. read_write is always 0.
// ----------------------------------------------------------------------------
module char_lcd_bus_writer import clbw_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   clbw_req_if.sink                   req_bus,
   clbw_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    push, pop, q_full, q_empty;
   job_type push_job, head;

   // --- config registers ----------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_BUS_MODE:    cfg_in.bus_mode       = csr_pwdata[0];
            REG_ENABLE_HIGH: cfg_in.enable_high_ms = csr_pwdata[BYTE_W-1:0];
            REG_ENABLE_LOW:  cfg_in.enable_low_ms  = csr_pwdata[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;   // unmapped: dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BUS_MODE:    csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.bus_mode};
         REG_ENABLE_HIGH: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, cfg_ff.enable_high_ms};
         REG_ENABLE_LOW:  csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, cfg_ff.enable_low_ms};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_mode       <= BUS_MODE_8BIT;
         cfg_ff.enable_high_ms <= 8'd1;
         cfg_ff.enable_low_ms  <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- front: decode requests, sequence the init list ----------------------
   clbw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_bus),
      .push     (push),
      .push_job (push_job),
      .q_full   (q_full)
   );

   // --- job queue: lets decode and phase output stall independently ---------
   clbw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   // --- back: one bus phase per beat ----------------------------------------
   clbw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp     (rsp_bus)
   );

endmodule
`default_nettype wire
